>>> rtl/asbb_pkg.sv
package asbb_pkg;

    localparam int DEF_CORDIC_STEPS = 24;
    localparam int DEF_COORD_BITS   = 32;

    localparam logic [18:0] FULL_TURN = 19'd360000;
    localparam logic [18:0] HALF_TURN = 19'd180000;
    localparam logic [18:0] QUARTER   = 19'd90000;
    localparam logic [18:0] THREE_Q   = 19'd270000;
    localparam logic signed [33:0] GAIN30 = 34'sd652032874;
    localparam logic signed [47:0] OUT_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] OUT_MIN = 48'sh8000_0000_0000;

    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic [29:0]        outer_radius;
        logic [29:0]        inner_radius;
        logic [18:0]        start_angle;
        logic [18:0]        end_angle;
        logic [15:0]        repeat_x;
        logic [15:0]        repeat_y;
        logic signed [31:0] pitch_x;
        logic signed [31:0] pitch_y;
    } t_in_item;

    typedef struct packed {
        logic signed [47:0] box_left;
        logic signed [47:0] box_right;
        logic signed [47:0] box_bottom;
        logic signed [47:0] box_top;
        logic signed [47:0] rep_left;
        logic signed [47:0] rep_right;
        logic signed [47:0] rep_bottom;
        logic signed [47:0] rep_top;
        logic signed [47:0] union_left;
        logic signed [47:0] union_right;
        logic signed [47:0] union_bottom;
        logic signed [47:0] union_top;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture input item, prepare angles
        logic trig_init; // start CORDIC for angle selected by trig_sel
        logic trig_zdiv; // finish angle scaling into the z register
        logic trig_step;
        logic trig_sel;  // 0: start angle, 1: end angle
        logic trig_done; // store rounded result of current run
        logic mult;      // one radius*trig product per cycle, index in mul_idx
        logic [2:0] mul_idx;
        logic edges;     // apply quadrant rules
        logic finish;    // rounding and repeat extents
        logic commit;    // saturate and update union
    } t_cmd;

    typedef struct packed {
        logic full;      // full circle, skip trig
        logic step_last;
    } t_sts;

    function automatic logic signed [31:0] atan_val(input int i);
        logic signed [31:0] t [32];
        t = '{32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
              32'sd42667331, 32'sd21354465, 32'sd10679838, 32'sd5340245,
              32'sd2670163, 32'sd1335087, 32'sd667544, 32'sd333772,
              32'sd166886, 32'sd83443, 32'sd41722, 32'sd20861, 32'sd10430,
              32'sd5215, 32'sd2608, 32'sd1304, 32'sd652, 32'sd326, 32'sd163,
              32'sd81, 32'sd41, 32'sd20, 32'sd10, 32'sd5, 32'sd3, 32'sd1,
              32'sd1, 32'sd0};
        return t[i[4:0]];
    endfunction

endpackage

>>> rtl/asbb_ctrl.sv
module asbb_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  asbb_pkg::t_sts   i_sts,
    output asbb_pkg::t_cmd   o_cmd
);
    import asbb_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DECODE= 4'd1;
    localparam logic [3:0] S_INIT  = 4'd2;
    localparam logic [3:0] S_STEP  = 4'd3;
    localparam logic [3:0] S_STORE = 4'd4;
    localparam logic [3:0] S_MULT  = 4'd5;
    localparam logic [3:0] S_EDGES = 4'd6;
    localparam logic [3:0] S_FIN   = 4'd7;
    localparam logic [3:0] S_COMMIT= 4'd8;
    localparam logic [3:0] S_ZDIV  = 4'd9;

    logic [3:0] r_state, n_state;
    logic       r_sel, n_sel;
    logic [2:0] r_mi, n_mi;
    logic       r_out_valid, n_out_valid;
    logic       busy_ok;

    // the result register may still be waiting; commit only when it is free
    assign busy_ok     = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        n_sel = r_sel;
        n_mi = r_mi;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd = '0;
        o_cmd.trig_sel = r_sel;
        o_cmd.mul_idx = r_mi;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_sel = 1'b0;
                n_state = i_sts.full ? S_FIN : S_INIT;
            end
            S_INIT: begin
                o_cmd.trig_init = 1'b1;
                n_state = S_ZDIV;
            end
            S_ZDIV: begin
                o_cmd.trig_zdiv = 1'b1;
                n_state = S_STEP;
            end
            S_STEP: begin
                o_cmd.trig_step = 1'b1;
                if (i_sts.step_last) n_state = S_STORE;
            end
            S_STORE: begin
                o_cmd.trig_done = 1'b1;
                if (r_sel) begin
                    n_mi = '0;
                    n_state = S_MULT;
                end else begin
                    n_sel = 1'b1;
                    n_state = S_INIT;
                end
            end
            S_MULT: begin
                o_cmd.mult = 1'b1;
                n_mi = r_mi + 3'd1;
                if (r_mi == 3'd7) n_state = S_EDGES;
            end
            S_EDGES: begin
                o_cmd.edges = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (busy_ok) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel <= 1'b0;
            r_mi <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sel <= n_sel;
            r_mi <= n_mi;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> rtl/asbb_dp.sv
module asbb_dp #(
    parameter int CORDIC_STEPS = asbb_pkg::DEF_CORDIC_STEPS,
    parameter int COORD_BITS   = asbb_pkg::DEF_COORD_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  asbb_pkg::t_in_item i_item,
    input  asbb_pkg::t_cmd     i_cmd,
    output asbb_pkg::t_sts     o_sts,
    output asbb_pkg::t_out_item o_item
);
    import asbb_pkg::*;

    localparam int CW = (COORD_BITS < 32) ? COORD_BITS : 32;
    localparam int SW = $clog2(CORDIC_STEPS + 1);

    // captured item
    logic signed [31:0] r_xc, r_yc, r_px, r_py;
    logic [29:0] r_r1, r_r2;
    logic [18:0] r_a1, r_a2;
    logic [15:0] r_nx, r_ny;
    logic        r_full;

    logic [18:0] a1c, a2c, a1n, a2n;
    always_comb begin
        a1c = (i_item.start_angle > FULL_TURN) ? FULL_TURN : i_item.start_angle;
        a2c = (i_item.end_angle > FULL_TURN) ? FULL_TURN : i_item.end_angle;
        a1n = (a1c == FULL_TURN) ? 19'd0 : a1c;
        a2n = (a2c == 19'd0) ? FULL_TURN : a2c;
    end

    // CORDIC unit
    logic [18:0]        ang;
    logic [1:0]         q;
    logic [16:0]        rem;
    logic [1:0]         r_q;
    logic signed [33:0] r_cx, r_cy;
    logic signed [33:0] r_cz;
    logic [SW-1:0]      r_i;
    logic [30:0]        zbase;
    logic [31:0]        zmid;
    logic [30:0]        r_zb;
    logic [27:0]        r_zm;
    logic [56:0]        zprod;
    logic signed [33:0] dx, dy, atn;
    logic signed [33:0] cr, sr;
    logic signed [26:0] c1, s1, c2, s2, cc, ss;

    assign ang = i_cmd.trig_sel ? r_a2 : r_a1;
    always_comb begin
        if (ang >= THREE_Q) begin
            q = 2'd3; rem = 17'(ang - THREE_Q);
        end else if (ang >= HALF_TURN) begin
            q = 2'd2; rem = 17'(ang - HALF_TURN);
        end else if (ang >= QUARTER) begin
            q = 2'd1; rem = 17'(ang - QUARTER);
        end else begin
            q = 2'd0; rem = 17'(ang);
        end
        if (ang == FULL_TURN) begin
            q = 2'd0; rem = '0;
        end
        // rem*2^30/90000 rounded: 2^30 = 11930*90000 + 41824, so the
        // quotient is rem*11930 plus (rem*41824 + 45000)/90000; the small
        // part is divided by 16 and then by 5625 through a reciprocal
        zbase = 31'(rem) * 31'd11930;
        zmid  = 32'(rem) * 32'd41824 + 32'd45000;
        zprod = 57'(r_zm) * 57'd390937468;
        dx   = r_cy >>> r_i;
        dy   = r_cx >>> r_i;
        atn  = 34'(atan_val(int'(r_i)));
        cr   = (r_cx + 34'sd32) >>> 6;
        sr   = (r_cy + 34'sd32) >>> 6;
        case (r_q)
            2'd1:    begin cc = -27'(sr); ss = 27'(cr);  end
            2'd2:    begin cc = -27'(cr); ss = -27'(sr); end
            2'd3:    begin cc = 27'(sr);  ss = -27'(cr); end
            default: begin cc = 27'(cr);  ss = 27'(sr);  end
        endcase
    end
    assign o_sts.step_last = (r_i == SW'(CORDIC_STEPS - 1));
    assign o_sts.full = r_full;

    // products
    logic signed [30:0] mr;
    logic signed [26:0] mt;
    logic signed [57:0] prod;
    logic signed [57:0] r_p [8];
    always_comb begin
        mr = i_cmd.mul_idx[2] ? $signed({1'b0, r_r2}) : $signed({1'b0, r_r1});
        case (i_cmd.mul_idx[1:0])
            2'd0:    mt = c1;
            2'd1:    mt = c2;
            2'd2:    mt = s1;
            default: mt = s2;
        endcase
        prod = 58'(mr * mt);
    end

    // edges in 24-fraction fixed point
    logic signed [57:0] bx, by, br1;
    logic signed [57:0] t1, t2, lo, hi, yl, yh, u1, u2;
    logic signed [57:0] r_lo, r_hi, r_yl, r_yh;
    always_comb begin
        bx  = 58'(r_xc) <<< 24;
        by  = 58'(r_yc) <<< 24;
        br1 = $signed({28'd0, r_r1}) <<< 24;
        t1 = bx + r_p[0]; t2 = bx + r_p[1];
        if (t1 < t2) begin lo = t1; hi = t2; end else begin lo = t2; hi = t1; end
        if (r_a1 <= HALF_TURN && (r_a2 >= HALF_TURN || r_a2 < r_a1)) lo = bx - br1;
        else if (r_a2 >= HALF_TURN && r_a2 < r_a1) lo = bx - br1;
        if (r_a1 == 19'd0 || r_a2 == FULL_TURN || r_a1 > r_a2) hi = bx + br1;
        t1 = by + r_p[2]; t2 = by + r_p[3];
        if (t1 < t2) begin yl = t1; yh = t2; end else begin yl = t2; yh = t1; end
        if (r_a1 <= THREE_Q && (r_a2 < r_a1 || r_a2 >= THREE_Q)) yl = by - br1;
        if (r_a2 >= QUARTER && (r_a1 > r_a2 || r_a1 <= QUARTER)) yh = by + br1;
        if (r_r2 != '0) begin
            u1 = bx + r_p[4]; u2 = bx + r_p[5];
            if (u1 < lo) lo = u1;
            if (u2 < lo) lo = u2;
            if (u1 > hi) hi = u1;
            if (u2 > hi) hi = u2;
            u1 = by + r_p[6]; u2 = by + r_p[7];
            if (u1 < yl) yl = u1;
            if (u2 < yl) yl = u2;
            if (u1 > yh) yh = u1;
            if (u2 > yh) yh = u2;
        end else begin
            u1 = '0; u2 = '0;
            if (r_a1 >= THREE_Q && (r_a2 > r_a1 || r_a2 <= QUARTER)) lo = bx;
            else if (r_a1 <= QUARTER && r_a2 <= QUARTER && r_a2 > r_a1) lo = bx;
            if (r_a1 >= QUARTER && r_a2 <= THREE_Q && r_a2 > r_a1) hi = bx;
            if (r_a2 <= HALF_TURN && r_a2 > r_a1) yl = by;
            if (r_a1 >= HALF_TURN && r_a2 > r_a1) yh = by;
        end
    end

    // finish: box edges and repeat extents
    logic signed [47:0] r_bl, r_br, r_bb, r_bt;
    logic signed [49:0] r_rl, r_rr, r_rb, r_rt;
    logic signed [47:0] fl, fr, fb, ft;
    logic signed [48:0] ex, ey;
    logic signed [49:0] rl, rr, rb, rt;
    logic signed [57:0] nh, nyh;
    always_comb begin
        nh  = -r_hi;
        nyh = -r_yh;
        if (r_full) begin
            fl = 48'(r_xc) - 48'(r_r1); fr = 48'(r_xc) + 48'(r_r1);
            fb = 48'(r_yc) - 48'(r_r1); ft = 48'(r_yc) + 48'(r_r1);
        end else begin
            fl = 48'(r_lo >>> 24);
            fr = -48'(nh >>> 24);
            fb = 48'(r_yl >>> 24);
            ft = -48'(nyh >>> 24);
        end
        ex = 49'($signed({1'b0, r_nx}) * r_px);
        ey = 49'($signed({1'b0, r_ny}) * r_py);
        rl = 50'(fl); rr = 50'(fr); rb = 50'(fb); rt = 50'(ft);
        if (ex < 0) rl = rl + 50'(ex); else rr = rr + 50'(ex);
        if (ey < 0) rb = rb + 50'(ey); else rt = rt + 50'(ey);
    end

    function automatic logic signed [47:0] sat(input logic signed [49:0] v);
        if (v > 50'(OUT_MAX)) return OUT_MAX;
        if (v < 50'(OUT_MIN)) return OUT_MIN;
        return v[47:0];
    endfunction

    logic signed [47:0] sl, sr2, sb, st;
    assign sl = sat(r_rl); assign sr2 = sat(r_rr);
    assign sb = sat(r_rb); assign st = sat(r_rt);

    logic r_empty;
    logic signed [47:0] r_al, r_ar, r_ab, r_at;
    t_out_item r_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_xc <= 32'($signed(i_item.center_x[CW-1:0]));
            r_yc <= 32'($signed(i_item.center_y[CW-1:0]));
            r_px <= 32'($signed(i_item.pitch_x[CW-1:0]));
            r_py <= 32'($signed(i_item.pitch_y[CW-1:0]));
            r_r1 <= i_item.outer_radius;
            r_r2 <= i_item.inner_radius;
            r_a1 <= a1n;
            r_a2 <= a2n;
            r_nx <= i_item.repeat_x;
            r_ny <= i_item.repeat_y;
            r_full <= (a1n == 19'd0) && (a2n == FULL_TURN);
        end
        if (i_cmd.trig_init) begin
            r_cx <= GAIN30;
            r_cy <= '0;
            r_zb <= zbase;
            r_zm <= zmid[31:4];
            r_q  <= q;
            r_i  <= '0;
        end
        if (i_cmd.trig_zdiv) begin
            r_cz <= 34'(r_zb) + 34'(zprod[56:41]);
        end
        if (i_cmd.trig_step) begin
            if (r_cz >= 0) begin
                r_cx <= r_cx - dx; r_cy <= r_cy + dy; r_cz <= r_cz - atn;
            end else begin
                r_cx <= r_cx + dx; r_cy <= r_cy - dy; r_cz <= r_cz + atn;
            end
            r_i <= r_i + SW'(1);
        end
        if (i_cmd.trig_done) begin
            if (i_cmd.trig_sel) begin c2 <= cc; s2 <= ss; end
            else begin c1 <= cc; s1 <= ss; end
        end
        if (i_cmd.mult) r_p[i_cmd.mul_idx] <= prod;
        if (i_cmd.edges) begin
            r_lo <= lo; r_hi <= hi; r_yl <= yl; r_yh <= yh;
        end
        if (i_cmd.finish) begin
            r_bl <= fl; r_br <= fr; r_bb <= fb; r_bt <= ft;
            r_rl <= rl; r_rr <= rr; r_rb <= rb; r_rt <= rt;
        end
        if (i_cmd.commit) begin
            r_out.box_left <= r_bl;  r_out.box_right <= r_br;
            r_out.box_bottom <= r_bb; r_out.box_top <= r_bt;
            r_out.rep_left <= sl;  r_out.rep_right <= sr2;
            r_out.rep_bottom <= sb; r_out.rep_top <= st;
            r_out.union_left   <= (r_empty || sl < r_al)  ? sl  : r_al;
            r_out.union_right  <= (r_empty || sr2 > r_ar) ? sr2 : r_ar;
            r_out.union_bottom <= (r_empty || sb < r_ab)  ? sb  : r_ab;
            r_out.union_top    <= (r_empty || st > r_at)  ? st  : r_at;
        end
        if (!i_rst_n) begin
            r_empty <= 1'b1;
            r_al <= '0; r_ar <= '0; r_ab <= '0; r_at <= '0;
        end else if (i_cmd.commit) begin
            r_empty <= 1'b0;
            r_al <= (r_empty || sl < r_al)  ? sl  : r_al;
            r_ar <= (r_empty || sr2 > r_ar) ? sr2 : r_ar;
            r_ab <= (r_empty || sb < r_ab)  ? sb  : r_ab;
            r_at <= (r_empty || st > r_at)  ? st  : r_at;
        end
    end

    assign o_item = r_out;

endmodule

>>> rtl/arc_sector_bounding_box_unit.sv
// Bounding box of one circle, arc, ring sector or pie element.
// Input channel i_in_valid/o_in_ready carries one element (t_in_item);
// output channel o_out_valid/i_out_ready carries its element box, the box
// widened by the repeat extent, and the running union of widened boxes.
// One element is worked on at a time. A full circle skips the trig work
// and goes from decode straight to the finish and commit steps; any other
// element makes two sequential runs of the single shared CORDIC rotator
// (angle scaling, steps, store) plus eight radius products through one
// multiplier. The next element is accepted the cycle after the result
// is committed to the output register, so a new element is not taken
// before the last one is through, and a result may wait there while the
// next element is already in work. If the receiver stalls, the finished
// element waits in the commit step until the output register frees.
// Reset (synchronous, active low) empties the union and drops any element
// in work or pending result.
module arc_sector_bounding_box_unit #(
    parameter int CORDIC_STEPS = asbb_pkg::DEF_CORDIC_STEPS,
    parameter int COORD_BITS   = asbb_pkg::DEF_COORD_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  asbb_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output asbb_pkg::t_out_item o_out_item
);
    import asbb_pkg::*;

    t_cmd cmd;
    t_sts sts;

    asbb_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .o_out_valid, .i_out_ready,
        .i_sts(sts), .o_cmd(cmd)
    );

    asbb_dp #(.CORDIC_STEPS(CORDIC_STEPS), .COORD_BITS(COORD_BITS)) u_dp (
        .i_clk, .i_rst_n, .i_item(i_in_item), .i_cmd(cmd), .o_sts(sts),
        .o_item(o_out_item)
    );

`ifndef SYNTHESIS
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({cmd.load, cmd.trig_step, cmd.mult, cmd.commit}) <= 1)
        else $error("overlapping datapath commands");
    a_commit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |=> o_out_valid)
        else $error("commit without result valid");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> (!o_out_valid || i_out_ready))
        else $error("result overwritten while stalled");
`endif

endmodule

>>> verif/arc_sector_bounding_box_unit_checker.sv
`timescale 1ns / 100ps

module arc_sector_bounding_box_unit_checker
    import asbb_pkg::*;
#(
    parameter int CORDIC_STEPS = DEF_CORDIC_STEPS,
    parameter int COORD_BITS   = DEF_COORD_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_item,
    output int        o_fail_count,
    output int        o_pending
);

    localparam longint MAX48 = 64'sd140737488355327;
    localparam longint MIN48 = -64'sd140737488355328;

    t_out_item box_queue[$];
    bit        union_empty;
    longint    acc_left, acc_right, acc_bottom, acc_top;

    assign o_pending = box_queue.size();

    // rotation-mode CORDIC, results at 24 fraction bits, quadrant mapped
    task automatic sin_cos(input int unsigned ang, output longint c, output longint s);
        int unsigned q, r;
        longint      z, x, y, dx, dy, cc, ss;
        q = ang / int'(QUARTER);
        r = ang - q * int'(QUARTER);
        z = ((longint'(r) <<< 30) + 45000) / int'(QUARTER);
        x = GAIN30;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> (i & 31);
            dy = x >>> (i & 31);
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_val(i & 31);
            end else begin
                x += dx; y -= dy; z += atan_val(i & 31);
            end
        end
        cc = (x + 32) >>> 6;
        ss = (y + 32) >>> 6;
        case (q & 3)
            1: begin c = -ss; s = cc; end
            2: begin c = -cc; s = -ss; end
            3: begin c = ss; s = -cc; end
            default: begin c = cc; s = ss; end
        endcase
    endtask

    function automatic longint coord(input logic [31:0] v);
        int cw;
        cw = COORD_BITS < 32 ? COORD_BITS : 32;
        return longint'(signed'(v << (32 - cw))) >>> (32 - cw);
    endfunction

    function automatic longint clip48(input longint v);
        return v > MAX48 ? MAX48 : (v < MIN48 ? MIN48 : v);
    endfunction

    function automatic longint ceil_frac(input longint v);
        return -((-v) >>> 24);
    endfunction

    task automatic predict_box(input t_in_item it);
        longint xc, yc, r1, r2, px, py, nx, ny, e;
        longint bl, br, bb, bt, rl, rr, rb, rt;
        longint xs, ys, rs, c1, s1, c2, s2, t1, t2, lo, hi, yl, yh;
        int unsigned a1, a2;
        t_out_item o;
        xc = coord(it.center_x); yc = coord(it.center_y);
        px = coord(it.pitch_x); py = coord(it.pitch_y);
        r1 = it.outer_radius; r2 = it.inner_radius;
        nx = it.repeat_x; ny = it.repeat_y;
        a1 = it.start_angle; a2 = it.end_angle;
        if (a1 > FULL_TURN) a1 = FULL_TURN;
        if (a2 > FULL_TURN) a2 = FULL_TURN;
        if (a1 == FULL_TURN) a1 = 0;
        if (a2 == 0) a2 = FULL_TURN;
        if (a1 == 0 && a2 == FULL_TURN) begin
            bl = xc - r1; br = xc + r1; bb = yc - r1; bt = yc + r1;
        end else begin
            xs = xc <<< 24; ys = yc <<< 24; rs = r1 <<< 24;
            sin_cos(a1, c1, s1);
            sin_cos(a2, c2, s2);
            t1 = xs + r1 * c1; t2 = xs + r1 * c2;
            lo = t1 < t2 ? t1 : t2; hi = t1 < t2 ? t2 : t1;
            if (a1 <= HALF_TURN && (a2 >= HALF_TURN || a2 < a1)) lo = xs - rs;
            else if (a2 >= HALF_TURN && a2 < a1) lo = xs - rs;
            if (a1 == 0 || a2 == FULL_TURN || a1 > a2) hi = xs + rs;
            t1 = ys + r1 * s1; t2 = ys + r1 * s2;
            yl = t1 < t2 ? t1 : t2; yh = t1 < t2 ? t2 : t1;
            if (a1 <= THREE_Q && (a2 < a1 || a2 >= THREE_Q)) yl = ys - rs;
            if (a2 >= QUARTER && (a1 > a2 || a1 <= QUARTER)) yh = ys + rs;
            if (r2 != 0) begin
                t1 = xs + r2 * c1; t2 = xs + r2 * c2;
                if (t1 < lo) lo = t1;
                if (t2 < lo) lo = t2;
                if (t1 > hi) hi = t1;
                if (t2 > hi) hi = t2;
                t1 = ys + r2 * s1; t2 = ys + r2 * s2;
                if (t1 < yl) yl = t1;
                if (t2 < yl) yl = t2;
                if (t1 > yh) yh = t1;
                if (t2 > yh) yh = t2;
            end else begin
                // pie: center is a corner of the sector
                if (a1 >= THREE_Q && (a2 > a1 || a2 <= QUARTER)) lo = xs;
                else if (a1 <= QUARTER && a2 <= QUARTER && a2 > a1) lo = xs;
                if (a1 >= QUARTER && a2 <= THREE_Q && a2 > a1) hi = xs;
                if (a2 <= HALF_TURN && a2 > a1) yl = ys;
                if (a1 >= HALF_TURN && a2 > a1) yh = ys;
            end
            bl = lo >>> 24; br = ceil_frac(hi);
            bb = yl >>> 24; bt = ceil_frac(yh);
        end
        rl = bl; rr = br; rb = bb; rt = bt;
        if (nx != 0) begin
            e = nx * px;
            if (e < 0) rl += e; else rr += e;
        end
        if (ny != 0) begin
            e = ny * py;
            if (e < 0) rb += e; else rt += e;
        end
        rl = clip48(rl); rr = clip48(rr); rb = clip48(rb); rt = clip48(rt);
        if (union_empty) begin
            acc_left = rl; acc_right = rr; acc_bottom = rb; acc_top = rt;
            union_empty = 0;
        end else begin
            if (rl < acc_left) acc_left = rl;
            if (rr > acc_right) acc_right = rr;
            if (rb < acc_bottom) acc_bottom = rb;
            if (rt > acc_top) acc_top = rt;
        end
        o = '{bl[47:0], br[47:0], bb[47:0], bt[47:0], rl[47:0], rr[47:0],
              rb[47:0], rt[47:0], acc_left[47:0], acc_right[47:0],
              acc_bottom[47:0], acc_top[47:0]};
        box_queue.push_back(o);
    endtask

    task automatic report_mismatch(input string what, input logic [47:0] got,
                                   input logic [47:0] want);
        $display("[%0t] MISMATCH %s: got %0d expected %0d", $realtime, what,
                 $signed(got), $signed(want));
        o_fail_count++;
    endtask

    task automatic compare_box(input t_out_item got, input t_out_item want);
        logic [47:0] g[12], w[12];
        string names[12];
        names = '{"box_left", "box_right", "box_bottom", "box_top", "rep_left",
                  "rep_right", "rep_bottom", "rep_top", "union_left",
                  "union_right", "union_bottom", "union_top"};
        {g[0], g[1], g[2], g[3], g[4], g[5], g[6], g[7], g[8], g[9], g[10], g[11]} = got;
        {w[0], w[1], w[2], w[3], w[4], w[5], w[6], w[7], w[8], w[9], w[10], w[11]} = want;
        for (int k = 0; k < 12; k++)
            if (g[k] !== w[k]) report_mismatch(names[k], g[k], w[k]);
    endtask

    initial begin
        o_fail_count = 0;
        union_empty  = 1;
        acc_left = 0; acc_right = 0; acc_bottom = 0; acc_top = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (box_queue.size() == 0) begin
                    $display("[%0t] unexpected result item", $realtime);
                    o_fail_count++;
                end else begin
                    compare_box(i_out_item, box_queue.pop_front());
                end
            end
            if (i_in_valid && i_in_ready) predict_box(i_in_item);
        end
    end

endmodule

>>> verif/arc_sector_bounding_box_unit_test.sv
`timescale 1ns / 100ps

module arc_sector_bounding_box_unit_test;
    import asbb_pkg::*;

    localparam int RANDOM_ITEMS = 1800;

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_item;
    int        fail_count;
    int        pending;
    bit        stim_done;

    arc_sector_bounding_box_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_item(in_item),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_item(out_item)
    );

    arc_sector_bounding_box_unit_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_item(in_item),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_item(out_item),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial i_clk = 0;
    always #1 i_clk = ~i_clk;

    function automatic logic [18:0] pick_angle();
        case ($urandom_range(0, 9))
            0: return 19'd0;
            1: return FULL_TURN;
            2: return 19'(32'(QUARTER) * $urandom_range(1, 3));
            3: return 19'($urandom_range(360001, 524287));
            4: return 19'(32'(QUARTER) * $urandom_range(0, 4) + $urandom_range(0, 2) - 1);
            default: return 19'($urandom_range(0, 360000));
        endcase
    endfunction

    function automatic t_in_item random_element();
        t_in_item it;
        it = t_in_item'({$urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom, $urandom});
        if ($urandom_range(0, 2) != 0) begin
            // mostly modest sizes
            it.center_x = $signed($urandom_range(0, 2000000)) - 1000000;
            it.center_y = $signed($urandom_range(0, 2000000)) - 1000000;
            it.outer_radius = 30'($urandom_range(0, 100000));
            it.inner_radius = $urandom_range(0, 3) == 0 ? 30'd0
                                                        : 30'($urandom_range(0, 100000));
            it.pitch_x = $signed($urandom_range(0, 20000)) - 10000;
            it.pitch_y = $signed($urandom_range(0, 20000)) - 10000;
            it.repeat_x = $urandom_range(0, 3) == 0 ? 16'd0 : 16'($urandom_range(0, 100));
            it.repeat_y = $urandom_range(0, 3) == 0 ? 16'd0 : 16'($urandom_range(0, 100));
        end
        if ($urandom_range(0, 4) == 0) it.inner_radius = 30'd0;
        it.start_angle = pick_angle();
        it.end_angle = pick_angle();
        return it;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_element(input t_in_item it);
        int gap;
        gap = $urandom_range(0, 4);
        if (gap != 0) begin
            in_valid <= 0;
            repeat (gap) @(negedge i_clk);
        end
        in_item  <= it;
        in_valid <= 1;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic directed_elements();
        t_in_item it;
        it = '0;
        it.outer_radius = 30'd1000;
        send_element(it);                         // full circle
        it.inner_radius = 30'd500;
        it.start_angle = QUARTER; it.end_angle = HALF_TURN;
        send_element(it);
        it.inner_radius = 30'd0;
        send_element(it);                         // pie
        it.start_angle = THREE_Q; it.end_angle = QUARTER;
        send_element(it);                         // wraps through zero
        it.start_angle = 19'd45000; it.end_angle = 19'd45000;
        send_element(it);                         // equal angles
        it.start_angle = 19'h7FFFF; it.end_angle = 19'h7FFFF;
        send_element(it);                         // clamped angles
        it.start_angle = FULL_TURN; it.end_angle = 19'd0;
        send_element(it);
        it = '1;
        it.center_x = 32'sh7FFFFFFF; it.center_y = 32'sh80000000;
        it.pitch_x = 32'sh7FFFFFFF; it.pitch_y = 32'sh80000000;
        it.start_angle = 19'd10000; it.end_angle = 19'd350000;
        send_element(it);                         // rep saturation
        it.center_x = 32'sh80000000; it.center_y = 32'sh7FFFFFFF;
        it.pitch_x = 32'sh80000000; it.pitch_y = 32'sh7FFFFFFF;
        it.start_angle = 19'd0; it.end_angle = 19'd0;
        send_element(it);
        it.inner_radius = 30'd0; it.start_angle = HALF_TURN; it.end_angle = THREE_Q;
        send_element(it);
        it = '0;
        it.outer_radius = 30'h3FFFFFFF; it.start_angle = 19'd1;
        it.end_angle = 19'd359999; it.repeat_x = 16'd3; it.pitch_x = -32'sd7;
        send_element(it);
    endtask

    initial begin
        in_valid = 0;
        in_item  = '0;
        out_ready = 0;
        stim_done = 0;
        i_rst_n = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;
        directed_elements();
        for (int n = 0; n < RANDOM_ITEMS; n++) send_element(random_element());
        in_valid <= 0;
        stim_done = 1;
        wait (pending == 0);
        repeat (80) @(posedge i_clk);
        if (fail_count == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

    // receiver: random stall before taking each item
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            gap = $urandom_range(0, 4);
            if (gap != 0) begin
                out_ready <= 0;
                repeat (gap) @(negedge i_clk);
            end
            out_ready <= 1;
            @(posedge i_clk);
            while (!out_valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
